/* sv/tklc_pkg.sv */
// Shared types, register indexes and fixed constants of the touch-key lamp controller.
package tklc_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int HOLD_W    = 15;
  localparam int REL_W     = 10;
  localparam int LEVEL_W   = 3;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CALSUM_W  = 21;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_DEADBAND       = 3'd0;
  localparam cfg_idx_t CFG_TOUCH_MARGIN   = 3'd1;
  localparam cfg_idx_t CFG_RELEASE_MARGIN = 3'd2;
  localparam cfg_idx_t CFG_LEVEL_STEP     = 3'd3;
  localparam cfg_idx_t CFG_RECAL          = 3'd4;
  localparam cfg_idx_t CFG_TOGGLE         = 3'd5;

  localparam logic OP_CALIB = 1'b0;
  localparam logic OP_RUN   = 1'b1;

  localparam logic [7:0]        DEADBAND_RST       = 8'd15;
  localparam logic [9:0]        TOUCH_MARGIN_RST   = 10'd50;
  localparam logic [9:0]        RELEASE_MARGIN_RST = 10'd10;
  localparam logic [HOLD_W-1:0] LEVEL_STEP_RST     = 15'd15000;
  localparam logic [HOLD_W-1:0] RECAL_RST          = 15'd30000;
  localparam logic [HOLD_W-1:0] TOGGLE_RST         = 15'd500;

  localparam logic [HOLD_W-1:0]  HOLD_MAX    = 15'h7FFF;
  localparam logic [HOLD_W-1:0]  HOLD_RELOAD = 15'd1000;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN   = 3'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 3'd7;

  typedef struct packed {
    logic                op;
    logic [SAMPLE_W-1:0] sample;
    logic                sample_new;
  } item_t;

  typedef struct packed {
    logic [2:0]         lamp_bits;
    logic               lamp_on;
    logic [LEVEL_W-1:0] colour_level;
    logic               calibrated;
  } result_t;

  // Colour level to the three drive bits; bit 0 drives the first output.
  function automatic logic [2:0] colour_bits(input logic [LEVEL_W-1:0] level);
    logic [2:0] bits;
    case (level)
      3'd1:    bits = 3'b001;
      3'd2:    bits = 3'b010;
      3'd3:    bits = 3'b100;
      3'd4:    bits = 3'b011;
      3'd5:    bits = 3'b101;
      3'd6:    bits = 3'b110;
      3'd7:    bits = 3'b111;
      default: bits = 3'b000;
    endcase
    return bits;
  endfunction

endpackage

/* sv/touch_key_lamp_controller.sv */
// Top level of the touch-key lamp controller: input register, core and result register.
//
//  Channel  Handshake              Payload
//  -------  ---------------------  ----------------------------------------------
//  in       in_valid / in_stall    op, sample, sample_new
//  out      out_valid / out_stall  lamp_bits, lamp_on, colour_level, calibrated
//  cfg      cfg_we                 cfg_index, cfg_data (write only)
//
//  Every item gives one result: it waits in the input register, then the core's
//  next-state logic feeds the result register. One item is taken per cycle while
//  in_stall is low; the core's state feeds back through its next-state logic alone.
//  rst (synchronous, active high) resets valid flags, core state and configuration.
//  A stall on the result side holds the result register, then the input register,
//  and then raises in_stall; no result is dropped or repeated.
//
// The calibration average is found without a divider. Each sample is multiplied
// by a fixed reciprocal of the sample count on its way into the input register,
// and the core accumulates these scaled values. The baseline is then a bit slice
// of the accumulator, exact for every possible sum. The core keeps the filtered
// count, the hold and release counters, the colour level and the lamp state, and
// updates them once per transferred item. Configuration writes land directly in
// the core's registers.
module touch_key_lamp_controller import tklc_pkg::*; #(
  parameter int CALIB_SAMPLES       = 20,
  parameter int RELEASE_CLEAR_TICKS = 100,
  parameter int RELEASE_WRAP_TICKS  = 1000
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  cfg_idx_t            cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                op,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                sample_new,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          lamp_bits,
  output logic                lamp_on,
  output logic [LEVEL_W-1:0]  colour_level,
  output logic                calibrated
);

  // Reciprocal scaling: floor(sum * CAL_M / 2**CAL_P) equals the truncated
  // average for every sum that the calibration can reach.
  localparam int CAL_P    = CALSUM_W + $clog2(CALIB_SAMPLES);
  localparam int CAL_M    = ((1 << CAL_P) + CALIB_SAMPLES - 1) / CALIB_SAMPLES;
  localparam int MUL_W    = CAL_P + 1;
  localparam int SCALED_W = SAMPLE_W + MUL_W;

  logic                s1_valid;
  item_t               s1_item;
  logic [SCALED_W-1:0] s1_scaled;
  logic [SCALED_W-1:0] in_scaled;
  logic                in_xfer;
  logic                fire;
  logic                ob_ready;
  result_t             core_res;
  result_t             out_res;

  assign in_scaled = SCALED_W'(sample) * SCALED_W'(CAL_M);

  // The input register moves into the core whenever the result register can
  // take the result, so a full input register and a new transfer coexist.
  assign fire     = s1_valid && ob_ready;
  assign in_stall = s1_valid && !ob_ready;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item.op         <= op;
      s1_item.sample     <= sample;
      s1_item.sample_new <= sample_new;
      s1_scaled          <= in_scaled;
    end
  end

  tklc_core #(
    .CALIB_SAMPLES       (CALIB_SAMPLES),
    .RELEASE_CLEAR_TICKS (RELEASE_CLEAR_TICKS),
    .RELEASE_WRAP_TICKS  (RELEASE_WRAP_TICKS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (s1_item),
    .scaled    (s1_scaled),
    .result    (core_res)
  );

  tklc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res_in    (core_res),
    .ready     (ob_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (out_res)
  );

  assign lamp_bits    = out_res.lamp_bits;
  assign lamp_on      = out_res.lamp_on;
  assign colour_level = out_res.colour_level;
  assign calibrated   = out_res.calibrated;

endmodule

/* sv/tklc_core.sv */
// Controller state, configuration registers and the per-item next-state logic.
module tklc_core import tklc_pkg::*; #(
  parameter int CALIB_SAMPLES       = 20,
  parameter int RELEASE_CLEAR_TICKS = 100,
  parameter int RELEASE_WRAP_TICKS  = 1000
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  cfg_idx_t cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic fire,
  input  item_t item,
  input  logic [SAMPLE_W+CALSUM_W+$clog2(CALIB_SAMPLES):0] scaled,
  output result_t result
);

  localparam int CAL_P    = CALSUM_W + $clog2(CALIB_SAMPLES);
  localparam int MUL_W    = CAL_P + 1;
  localparam int ACC_W    = CALSUM_W + MUL_W;
  localparam int CNT_W    = $clog2(CALIB_SAMPLES + 1);

  localparam logic [CNT_W-1:0] CAL_N      = CNT_W'(CALIB_SAMPLES);
  localparam logic [REL_W:0]   REL_CLEAR  = (REL_W + 1)'(RELEASE_CLEAR_TICKS);
  localparam logic [REL_W:0]   REL_WRAP   = (REL_W + 1)'(RELEASE_WRAP_TICKS);

  logic [7:0]        deadband;
  logic [9:0]        touch_margin;
  logic [9:0]        release_margin;
  logic [HOLD_W-1:0] level_step_ticks;
  logic [HOLD_W-1:0] recal_ticks;
  logic [HOLD_W-1:0] toggle_ticks;

  logic [SAMPLE_W-1:0] baseline, baseline_next;
  logic [ACC_W-1:0]    calib_acc, calib_acc_next;
  logic [CNT_W-1:0]    calib_count, calib_count_next;
  logic [SAMPLE_W-1:0] held_count, held_count_next;
  logic [SAMPLE_W-1:0] filtered_count, filtered_count_next;
  logic [HOLD_W-1:0]   hold_ticks, hold_ticks_next;
  logic [REL_W-1:0]    release_ticks, release_ticks_next;
  logic [LEVEL_W-1:0]  level_reg, level_reg_next;
  logic                lamp_state, lamp_state_next;

  logic                done;
  logic [ACC_W-1:0]    acc_sum;
  logic [CNT_W-1:0]    cnt_inc;
  logic [SAMPLE_W-1:0] held_v;
  logic [SAMPLE_W-1:0] filt_v;
  logic                follow;
  logic                touch_zone;
  logic                free_zone;
  logic [HOLD_W-1:0]   hold_inc;
  logic [REL_W:0]      rel_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband         <= DEADBAND_RST;
      touch_margin     <= TOUCH_MARGIN_RST;
      release_margin   <= RELEASE_MARGIN_RST;
      level_step_ticks <= LEVEL_STEP_RST;
      recal_ticks      <= RECAL_RST;
      toggle_ticks     <= TOGGLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEADBAND:       deadband         <= cfg_data[7:0];
        CFG_TOUCH_MARGIN:   touch_margin     <= cfg_data[9:0];
        CFG_RELEASE_MARGIN: release_margin   <= cfg_data[9:0];
        CFG_LEVEL_STEP:     level_step_ticks <= cfg_data[HOLD_W-1:0];
        CFG_RECAL:          recal_ticks      <= cfg_data[HOLD_W-1:0];
        CFG_TOGGLE:         toggle_ticks     <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // The accumulator holds the calibration sum pre-scaled by the reciprocal
  // of the sample count, so the average is a plain bit slice of it.
  assign done    = (calib_count >= CAL_N);
  assign acc_sum = calib_acc + ACC_W'(scaled);
  assign cnt_inc = calib_count + CNT_W'(1);

  // All margin compares are rearranged into unsigned adds that cannot wrap.
  assign held_v = item.sample_new ? item.sample : held_count;
  assign follow = ({1'b0, held_v} > ({1'b0, filtered_count} + 17'(deadband))) ||
                  (({1'b0, held_v} + 17'(deadband)) < {1'b0, filtered_count});
  assign filt_v = follow ? held_v : filtered_count;
  assign touch_zone = ({1'b0, filt_v} + 17'(touch_margin)) < {1'b0, baseline};
  assign free_zone  = ({1'b0, filt_v} + 17'(release_margin)) > {1'b0, baseline};
  assign hold_inc   = (hold_ticks != HOLD_MAX) ? hold_ticks + HOLD_W'(1) : hold_ticks;
  assign rel_inc    = {1'b0, release_ticks} + (REL_W + 1)'(1);

  always_comb begin
    baseline_next       = baseline;
    calib_acc_next      = calib_acc;
    calib_count_next    = calib_count;
    held_count_next     = held_count;
    filtered_count_next = filtered_count;
    hold_ticks_next     = hold_ticks;
    release_ticks_next  = release_ticks;
    level_reg_next      = level_reg;
    lamp_state_next     = lamp_state;
    if (fire) begin
      if (item.op == OP_CALIB) begin
        if (!done) begin
          held_count_next  = item.sample;
          calib_acc_next   = acc_sum;
          calib_count_next = cnt_inc;
          if (cnt_inc >= CAL_N) begin
            baseline_next = acc_sum[CAL_P +: SAMPLE_W];
          end
        end
      end else if (done) begin
        held_count_next     = held_v;
        filtered_count_next = filt_v;
        if (touch_zone) begin
          hold_ticks_next = hold_inc;
          if (lamp_state && (hold_inc > level_step_ticks)) begin
            level_reg_next  = (level_reg == LEVEL_MAX) ? LEVEL_MIN : level_reg + LEVEL_W'(1);
            hold_ticks_next = HOLD_RELOAD;
          end else if (!lamp_state && (hold_inc > recal_ticks)) begin
            hold_ticks_next = '0;
            baseline_next   = filt_v;
          end
        end else if (free_zone) begin
          if (rel_inc > REL_CLEAR) begin
            hold_ticks_next = '0;
          end
          release_ticks_next = (rel_inc > REL_WRAP) ? '0 : rel_inc[REL_W-1:0];
        end
        if (hold_ticks_next == toggle_ticks) begin
          lamp_state_next = ~lamp_state;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline       <= '0;
      calib_acc      <= '0;
      calib_count    <= '0;
      held_count     <= '0;
      filtered_count <= '0;
      hold_ticks     <= '0;
      release_ticks  <= '0;
      level_reg      <= LEVEL_MIN;
      lamp_state     <= 1'b0;
    end else begin
      baseline       <= baseline_next;
      calib_acc      <= calib_acc_next;
      calib_count    <= calib_count_next;
      held_count     <= held_count_next;
      filtered_count <= filtered_count_next;
      hold_ticks     <= hold_ticks_next;
      release_ticks  <= release_ticks_next;
      level_reg      <= level_reg_next;
      lamp_state     <= lamp_state_next;
    end
  end

  always_comb begin
    result.lamp_bits    = lamp_state_next ? colour_bits(level_reg_next) : 3'b000;
    result.lamp_on      = lamp_state_next;
    result.colour_level = level_reg_next;
    result.calibrated   = (calib_count_next >= CAL_N);
  end

  a_level_nonzero: assert property (@(posedge clk) disable iff (rst)
    level_reg != '0)
    else $error("colour level left its range");

  a_idle_before_cal: assert property (@(posedge clk) disable iff (rst)
    (calib_count < CAL_N) |-> (!lamp_state && (hold_ticks == '0)))
    else $error("run state moved before calibration finished");

  a_release_bound: assert property (@(posedge clk) disable iff (rst)
    release_ticks <= REL_WRAP[REL_W-1:0])
    else $error("release count passed its wrap point");

  a_hold_without_fire: assert property (@(posedge clk) disable iff (rst)
    !fire |=> ($stable(lamp_state) && $stable(level_reg) && $stable(baseline)))
    else $error("state changed without an item");

endmodule

/* sv/tklc_out_buf.sv */
// Result register with valid/stall handshake toward the consumer.
module tklc_out_buf import tklc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  result_t res_in,
  output logic    ready,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t res
);

  // A new result may enter when the register is empty or is being emptied.
  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_in;
    end
  end

endmodule
